// File: sv/fcx_pkg.sv
package fcx_pkg;

   // Byte lanes of the 32-bit fold and the bits needed to name one
   localparam int unsigned LANES  = 4;
   localparam int unsigned LANE_W = $clog2(LANES);

   localparam logic [15:0] HEADER_BYTES_RESET = 16'd8;
   localparam logic [15:0] MAX_FRAME_RESET    = 16'd8192;

   // Default depth of the job queue between front and back
   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic OP_HEADER = 1'b0;
   localparam logic OP_BODY   = 1'b1;

   localparam logic CSR_HEADER_BYTES = 1'b0;
   localparam logic CSR_MAX_FRAME    = 1'b1;

   typedef enum logic [1:0] {
      STATUS_GOOD     = 2'd0,
      STATUS_FRAMING  = 2'd1,
      STATUS_MISMATCH = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      JOB_START   = 2'd0,
      JOB_FOLD    = 2'd1,
      JOB_FRAMING = 2'd2
   } job_kind_type;

   typedef struct packed {
      logic        operation;
      logic [15:0] frame_size;
      logic [15:0] packet_id;
      logic [31:0] expected_sum;
      logic [7:0]  data_byte;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] result_id;
      logic [31:0] computed_sum;
   } rsp_type;

   typedef struct packed {
      job_kind_type      kind;
      logic              last;
      logic [15:0]       id;
      logic [31:0]       sum;
      logic [7:0]        data;
      logic [LANE_W-1:0] lane;
   } job_type;

endpackage

// File: sv/fcx_queue.sv
module fcx_queue #(
   parameter int unsigned DEPTH = fcx_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  fcx_pkg::job_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output fcx_pkg::job_type pop_data
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   fcx_pkg::job_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: sv/fcx_front.sv
module fcx_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  fcx_pkg::req_type req_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [15:0]      csr_data,
   output logic             job_valid,
   input  logic             job_ready,
   output fcx_pkg::job_type job_data
);

   localparam int unsigned LW = fcx_pkg::LANE_W;

   logic        closed_ff, closed_in;
   logic        in_body_ff, in_body_in;
   logic [15:0] body_len_ff, body_len_in;
   logic [15:0] idx_ff, idx_in;
   logic [15:0] header_bytes_ff, max_frame_ff;

   logic        accept;
   logic [15:0] new_len;
   logic [15:0] next_idx;
   logic [15:0] whole_end;

   assign req_ready = job_ready;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && job_ready;
   assign new_len   = req_data.frame_size - header_bytes_ff;
   assign next_idx  = idx_ff + 16'd1;
   assign whole_end = {body_len_ff[15:LW], LW'(0)};

   always_comb begin
      closed_in     = closed_ff;
      in_body_in    = in_body_ff;
      body_len_in   = body_len_ff;
      idx_in        = idx_ff;
      job_valid     = 1'b0;
      job_data.kind = fcx_pkg::JOB_FOLD;
      job_data.last = 1'b0;
      job_data.id   = req_data.packet_id;
      job_data.sum  = req_data.expected_sum;
      job_data.data = req_data.data_byte;
      job_data.lane = '0;
      if (accept && !closed_ff) begin
         if (req_data.operation == fcx_pkg::OP_HEADER) begin
            if (!in_body_ff) begin
               job_valid = 1'b1;
               priority if (req_data.frame_size < header_bytes_ff ||
                            req_data.frame_size > max_frame_ff) begin
                  job_data.kind = fcx_pkg::JOB_FRAMING;
                  closed_in     = 1'b1;
               end else begin
                  job_data.kind = fcx_pkg::JOB_START;
                  job_data.last = (new_len == 16'd0);
                  body_len_in   = new_len;
                  idx_in        = 16'd0;
                  in_body_in    = (new_len != 16'd0);
               end
            end
         end else if (in_body_ff) begin
            job_valid     = 1'b1;
            job_data.kind = fcx_pkg::JOB_FOLD;
            job_data.lane = (idx_ff < whole_end) ? idx_ff[LW-1:0] : '0;
            idx_in        = next_idx;
            if (next_idx >= body_len_ff) begin
               job_data.last = 1'b1;
               in_body_in    = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         closed_ff       <= 1'b0;
         in_body_ff      <= 1'b0;
         body_len_ff     <= 16'd0;
         idx_ff          <= 16'd0;
         header_bytes_ff <= fcx_pkg::HEADER_BYTES_RESET;
         max_frame_ff    <= fcx_pkg::MAX_FRAME_RESET;
      end else begin
         closed_ff   <= closed_in;
         in_body_ff  <= in_body_in;
         body_len_ff <= body_len_in;
         idx_ff      <= idx_in;
         if (csr_valid) begin
            unique case (csr_index)
               fcx_pkg::CSR_HEADER_BYTES: header_bytes_ff <= csr_data;
               fcx_pkg::CSR_MAX_FRAME:    max_frame_ff    <= csr_data;
            endcase
         end
      end
   end

endmodule

// File: sv/fcx_back.sv
module fcx_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   output logic             job_ready,
   input  fcx_pkg::job_type job_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output fcx_pkg::rsp_type rsp_data
);

   logic             closed_ff, closed_in;
   logic [31:0]      acc_ff, acc_in;
   logic [15:0]      held_id_ff, held_id_in;
   logic [31:0]      held_sum_ff, held_sum_in;
   logic             rsp_valid_ff, rsp_valid_in;
   fcx_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic        take;
   logic [31:0] shifted;
   logic [31:0] fold_val;
   logic [31:0] sum_ref;
   logic [15:0] id_ref;

   assign job_ready = !rsp_valid_ff || rsp_ready;
   assign take      = job_valid && job_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign shifted  = 32'(job_data.data) << {job_data.lane, 3'b000};
   assign fold_val = (job_data.kind == fcx_pkg::JOB_START) ? 32'd0 : (acc_ff ^ shifted);
   assign sum_ref  = (job_data.kind == fcx_pkg::JOB_START) ? job_data.sum : held_sum_ff;
   assign id_ref   = (job_data.kind == fcx_pkg::JOB_START) ? job_data.id : held_id_ff;

   always_comb begin
      closed_in    = closed_ff;
      acc_in       = acc_ff;
      held_id_in   = held_id_ff;
      held_sum_in  = held_sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (take && !closed_ff) begin
         unique case (job_data.kind)
            fcx_pkg::JOB_FRAMING: begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.status       = fcx_pkg::STATUS_FRAMING;
               rsp_data_in.result_id    = job_data.id;
               rsp_data_in.computed_sum = 32'd0;
               closed_in                = 1'b1;
            end
            fcx_pkg::JOB_START, fcx_pkg::JOB_FOLD: begin
               acc_in      = fold_val;
               held_id_in  = id_ref;
               held_sum_in = sum_ref;
               if (job_data.last) begin
                  rsp_valid_in             = 1'b1;
                  rsp_data_in.result_id    = id_ref;
                  rsp_data_in.computed_sum = fold_val;
                  if (fold_val == sum_ref) begin
                     rsp_data_in.status = fcx_pkg::STATUS_GOOD;
                  end else begin
                     rsp_data_in.status = fcx_pkg::STATUS_MISMATCH;
                     closed_in          = 1'b1;
                  end
               end
            end
            default: begin
               closed_in = closed_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         closed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         closed_ff    <= closed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      held_id_ff  <= held_id_in;
      held_sum_ff <= held_sum_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// File: sv/frame_checker_xor_fold.sv
// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    fcx_pkg::req_type (header item or body byte)
// rsp       out        rsp_valid/rsp_ready    fcx_pkg::rsp_type (verdict of one packet)
// csr       in         csr_valid/csr_ready    csr_index, csr_data (header_bytes, max_frame_bytes)
//
// One item per cycle sustained while rsp is not stalled; the verdict for the last req
// transfer of a packet passes the job queue and then the output register before it
// is on rsp. The front is combinational.
// Reset is synchronous and active high; it restores header_bytes to 8 and
// max_frame_bytes to 8192 and empties the queue. No clearing pass is needed.
// A stall on rsp holds the output register; the queue then fills and req_ready
// drops only once QUEUE_DEPTH jobs wait. csr_ready is always high.
module frame_checker_xor_fold #(
   parameter int unsigned QUEUE_DEPTH = fcx_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  fcx_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output fcx_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [15:0]      csr_data
);

   // Jobs from the classifier into the queue
   logic             push_valid;
   logic             push_ready;
   fcx_pkg::job_type push_data;

   // Jobs from the queue into the fold engine
   logic             pop_valid;
   logic             pop_ready;
   fcx_pkg::job_type pop_data;

   // Front: classify each transfer against the framing state, drop what is ignored
   fcx_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .job_valid (push_valid),
      .job_ready (push_ready),
      .job_data  (push_data)
   );

   // Short queue: let front and back stall independently
   fcx_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Back: fold bytes, compare at the last one and hold the verdict for rsp.
   // A checksum mismatch closes the back; jobs queued after it are dropped there.
   fcx_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (pop_valid),
      .job_ready (pop_ready),
      .job_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// File: sv/fcx_checker.sv
module fcx_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input fcx_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp payload changed while stalled");

   a_framing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == fcx_pkg::STATUS_FRAMING |->
         rsp_data.computed_sum == 32'd0)
      else $error("framing error with non-zero sum");

   a_closed_after_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.status != fcx_pkg::STATUS_GOOD |=> !rsp_valid)
      else $error("result after an error transfer");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid straight after reset");

endmodule

bind frame_checker_xor_fold fcx_checker u_fcx_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
